/* design/dec_hex_number_parser_defines.svh */
// Assertion macros used by the checker file
`ifndef DEC_HEX_NUMBER_PARSER_DEFINES_SVH
`define DEC_HEX_NUMBER_PARSER_DEFINES_SVH

// same-cycle implication, masked during reset
`define DHP_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("dhp assertion failed");

// next-cycle implication, masked during reset
`define DHP_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("dhp assertion failed");

// next-cycle implication, live through reset
`define DHP_ASSERT_RST(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("dhp reset assertion failed");

`endif

/* design/dhp_pkg.sv */
package dhp_pkg;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_ZERO  = 3'd1;
  localparam logic [2:0] PH_HEX   = 3'd2;
  localparam logic [2:0] PH_DEC   = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_LEADING_ZERO = 3'd1;
  localparam logic [2:0] ST_BAD_HEX      = 3'd2;
  localparam logic [2:0] ST_BAD_DEC      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW     = 3'd4;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] err;
  } ctl_t;

endpackage

/* design/dhp_step.sv */
module dhp_step #(
  parameter int VALUE_BITS = 63
) (
  input  dhp_pkg::ctl_t          ctl_i,
  input  logic [VALUE_BITS-1:0]  acc_i,
  input  logic [7:0]             char_i,
  output dhp_pkg::ctl_t          ctl_o,
  output logic [VALUE_BITS-1:0]  acc_o
);
  import dhp_pkg::*;

  localparam int WW = VALUE_BITS + 5;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;

  logic          is_dec;
  logic          is_hex;
  logic [3:0]    digit;
  logic [WW-1:0] acc_w;
  logic [WW-1:0] scaled;
  logic [WW-1:0] sum;
  logic          ovf;
  logic [2:0]    new_err;

  always_comb begin
    is_dec = (char_i >= CH_0) && (char_i <= CH_9);
    is_hex = is_dec || ((char_i >= CH_LA) && (char_i <= CH_LF)) ||
             ((char_i >= CH_UA) && (char_i <= CH_UF));
    digit  = is_dec ? char_i[3:0] : char_i[3:0] + 4'd9;
    acc_w  = WW'(acc_i);
    if (ctl_i.phase == PH_HEX) begin
      scaled = acc_w << 4;
    end else begin
      scaled = (acc_w << 3) + (acc_w << 1);
    end
    sum = scaled + WW'(digit);
    ovf = |sum[WW-1:VALUE_BITS];
  end

  always_comb begin
    ctl_o   = ctl_i;
    acc_o   = acc_i;
    new_err = ST_OK;
    unique case (ctl_i.phase)
      PH_ZERO: begin
        if ((char_i == CH_LX) || (char_i == CH_UX)) begin
          ctl_o.phase = PH_HEX;
        end else begin
          new_err = ST_LEADING_ZERO;
        end
      end
      PH_HEX: begin
        if (!is_hex) begin
          new_err = ST_BAD_HEX;
        end else if (ovf) begin
          new_err = ST_OVERFLOW;
        end else begin
          acc_o = sum[VALUE_BITS-1:0];
        end
      end
      PH_DEC: begin
        if (!is_dec) begin
          new_err = ST_BAD_DEC;
        end else if (ovf) begin
          new_err = ST_OVERFLOW;
        end else begin
          acc_o = sum[VALUE_BITS-1:0];
        end
      end
      PH_DRAIN: begin
      end
      default: begin
        acc_o     = '0;
        ctl_o.err = ST_OK;
        if (char_i == CH_0) begin
          ctl_o.phase = PH_ZERO;
        end else if ((char_i >= CH_1) && (char_i <= CH_9)) begin
          acc_o       = VALUE_BITS'(char_i[3:0]);
          ctl_o.phase = PH_DEC;
        end else begin
          new_err = ST_BAD_DEC;
        end
      end
    endcase
    if (new_err != ST_OK) begin
      ctl_o.phase = PH_DRAIN;
      if (ctl_o.err == ST_OK) begin
        ctl_o.err = new_err;
      end
    end
  end

endmodule

/* design/dec_hex_number_parser.sv */
// Unsigned decimal / hex number token parser. One character is taken per
// cycle on the in_ stream, in_tlast on the final character of a token;
// every token has at least one character. The result for a token appears
// on the out_ stream in the cycle after its last character is taken, and
// characters keep flowing while the result register is full, except that
// in_tready drops while a held result is not being taken. The update per
// character is one shift-add by 10 or 16 with an overflow test, so the
// sustained rate is one character per cycle. out_tuser carries the status
// (0 ok, 1 leading zero, 2 bad hex digit, 3 bad decimal digit, 4 overflow);
// value saturates to all ones on overflow and is zero on other errors.
module dec_hex_number_parser #(
  parameter int VALUE_BITS = 63,
  localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_code
  input  logic              in_tlast,   // is_last
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [VALUE_BITS-1:0] value, zero padded
  output logic [2:0]        out_tuser   // [2:0] status
);
  import dhp_pkg::*;

  ctl_t                  ctl_r;
  ctl_t                  ctl_nxt;
  logic [VALUE_BITS-1:0] acc_r;
  logic [VALUE_BITS-1:0] acc_nxt;
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [VALUE_BITS-1:0] value_nxt;
  logic [2:0]            out_status_r;
  logic                  in_acc;

  dhp_step #(.VALUE_BITS(VALUE_BITS)) u_step (
    .ctl_i  (ctl_r),
    .acc_i  (acc_r),
    .char_i (in_tdata),
    .ctl_o  (ctl_nxt),
    .acc_o  (acc_nxt)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (ctl_nxt.err == ST_OVERFLOW) begin
      value_nxt = {VALUE_BITS{1'b1}};
    end else if (ctl_nxt.err != ST_OK) begin
      value_nxt = '0;
    end else begin
      value_nxt = acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '{phase: PH_START, err: ST_OK};
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_tlast) begin
          ctl_r <= '{phase: PH_START, err: ST_OK};
          acc_r <= '0;
        end else begin
          ctl_r <= ctl_nxt;
          acc_r <= acc_nxt;
        end
      end
      if (in_acc && in_tlast) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tlast) begin
      out_value_r  <= value_nxt;
      out_status_r <= ctl_nxt.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_value_r);
  assign out_tuser  = out_status_r;

endmodule

/* design/dhp_checker.sv */
`include "dec_hex_number_parser_defines.svh"

module dhp_checker #(
  parameter int VALUE_BITS = 63,
  localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              in_tlast,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic [2:0]        out_tuser
);
  import dhp_pkg::*;

  logic val_max;
  logic val_zero;

  assign val_max  = &out_tdata[VALUE_BITS-1:0];
  assign val_zero = out_tdata[VALUE_BITS-1:0] == '0;

  // a stalled result transaction holds
  `DHP_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `DHP_ASSERT_IMP(a_ovf_sat, clk, rst_n, out_tvalid && (out_tuser == ST_OVERFLOW), val_max)
  `DHP_ASSERT_IMP(a_err_zero, clk, rst_n,
                  out_tvalid && (out_tuser != ST_OK) && (out_tuser != ST_OVERFLOW), val_zero)
  `DHP_ASSERT_NXT(a_result, clk, rst_n, in_tvalid && in_tready && in_tlast, out_tvalid)
  `DHP_ASSERT_RST(a_rst, clk, !rst_n, !out_tvalid)

endmodule

bind dec_hex_number_parser dhp_checker #(.VALUE_BITS(VALUE_BITS)) u_dhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
